### sv/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg: shared types and constants
// Event kinds, parser phases, status byte codes and the queued event record.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned DeltaW = 28;

  typedef enum logic [1:0] {
    EV_NOTE_OFF = 2'd0,
    EV_NOTE_ON  = 2'd1,
    EV_END      = 2'd2,
    EV_ERROR    = 2'd3
  } event_kind_e;

  typedef enum logic [2:0] {
    PH_DELTA     = 3'd0,
    PH_HEAD      = 3'd1,
    PH_DATA1     = 3'd2,
    PH_DATA2     = 3'd3,
    PH_SKIP2     = 3'd4,
    PH_META_TYPE = 3'd5,
    PH_LEN       = 3'd6,
    PH_BODY      = 3'd7
  } phase_e;

  // status byte heads
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_ESCAPE  = 8'hF7;
  localparam logic [7:0] ST_META_LO = 8'hF8;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] META_EOT   = 8'h2F;

  // channel message commands (upper status nibble)
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_POLY_AT  = 4'hA;
  localparam logic [3:0] CMD_CTRL     = 4'hB;
  localparam logic [3:0] CMD_PROG     = 4'hC;
  localparam logic [3:0] CMD_PRESS    = 4'hD;
  localparam logic [3:0] CMD_BEND     = 4'hE;

  typedef struct packed {
    event_kind_e        kind;
    logic [3:0]         chan;
    logic [7:0]         note;
    logic [DeltaW-1:0]  delta;
  } event_t;

endpackage

### sv/mtep_front.sv
// ----------------------------------------------------------------------------
// mtep_front: track byte parser
// Decodes delta times, status with running status, data bytes and skips
// sysex/meta bodies; pushes note, end-of-track and error events.
// ----------------------------------------------------------------------------
module mtep_front
  import mtep_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_acc_i,
  input  logic [7:0] data_byte_i,
  output logic       push_o,
  output event_t     event_o
);

  phase_e             phase_q, phase_d;
  logic [7:0]         rs_q, rs_d;
  logic [DeltaW-1:0]  delta_q, delta_d;
  logic [DeltaW-1:0]  skip_q, skip_d;
  logic [7:0]         first_q, first_d;
  logic               meta_end_q, meta_end_d;

  logic               do_disp, do_finish, ev_push;
  logic [DeltaW-1:0]  skip_vlq, skip_dec;
  event_t             ev;

  assign skip_vlq = {skip_q[DeltaW-8:0], data_byte_i[6:0]};
  assign skip_dec = skip_q - DeltaW'(1);

  always_comb begin
    phase_d    = phase_q;
    rs_d       = rs_q;
    delta_d    = delta_q;
    skip_d     = skip_q;
    first_d    = first_q;
    meta_end_d = meta_end_q;
    do_disp    = 1'b0;
    do_finish  = 1'b0;
    ev_push    = 1'b0;
    ev.kind    = EV_NOTE_OFF;
    ev.chan    = '0;
    ev.note    = '0;
    ev.delta   = delta_q;

    unique case (phase_q)
      PH_DELTA: begin
        delta_d = {delta_q[DeltaW-8:0], data_byte_i[6:0]};
        phase_d = data_byte_i[7] ? PH_DELTA : PH_HEAD;
      end
      PH_HEAD: begin
        if (data_byte_i == ST_SYSEX || data_byte_i == ST_ESCAPE) begin
          rs_d       = '0;
          meta_end_d = 1'b0;
          skip_d     = '0;
          phase_d    = PH_LEN;
        end else if (data_byte_i >= ST_META_LO) begin
          meta_end_d = (data_byte_i == ST_META);
          phase_d    = PH_META_TYPE;
        end else if (data_byte_i[7]) begin
          rs_d    = data_byte_i;
          phase_d = PH_DATA1;
        end else begin
          // running status: this is already the first data byte
          first_d = data_byte_i;
          do_disp = 1'b1;
        end
      end
      PH_DATA1: begin
        first_d = data_byte_i;
        do_disp = 1'b1;
      end
      PH_DATA2: begin
        ev_push = 1'b1;
        ev.kind = (rs_q[7:4] == CMD_NOTE_ON && data_byte_i != 8'd0) ?
                  EV_NOTE_ON : EV_NOTE_OFF;
        ev.chan = rs_q[3:0];
        ev.note = first_q;
        phase_d = PH_DELTA;
        delta_d = '0;
      end
      PH_SKIP2: begin
        phase_d = PH_DELTA;
        delta_d = '0;
      end
      PH_META_TYPE: begin
        if (data_byte_i != META_EOT) begin
          meta_end_d = 1'b0;
        end
        skip_d  = '0;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        skip_d = skip_vlq;
        if (!data_byte_i[7]) begin
          if (skip_vlq == '0) begin
            do_finish = 1'b1;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          do_finish = 1'b1;
        end
      end
    endcase

    if (do_disp) begin
      unique case (rs_q[7:4])
        CMD_NOTE_OFF, CMD_NOTE_ON: begin
          phase_d = PH_DATA2;
        end
        CMD_POLY_AT, CMD_CTRL, CMD_BEND: begin
          phase_d = PH_SKIP2;
        end
        CMD_PROG, CMD_PRESS: begin
          phase_d = PH_DELTA;
          delta_d = '0;
        end
        default: begin
          // no usable status: report the data byte and drop running status
          ev_push = 1'b1;
          ev.kind = EV_ERROR;
          ev.note = data_byte_i;
          rs_d    = '0;
          phase_d = PH_DELTA;
          delta_d = '0;
        end
      endcase
    end

    if (do_finish) begin
      if (meta_end_q) begin
        ev_push = 1'b1;
        ev.kind = EV_END;
        rs_d    = '0;
      end
      meta_end_d = 1'b0;
      phase_d    = PH_DELTA;
      delta_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DELTA;
      rs_q       <= '0;
      delta_q    <= '0;
      skip_q     <= '0;
      first_q    <= '0;
      meta_end_q <= 1'b0;
    end else if (in_acc_i) begin
      phase_q    <= phase_d;
      rs_q       <= rs_d;
      delta_q    <= delta_d;
      skip_q     <= skip_d;
      first_q    <= first_d;
      meta_end_q <= meta_end_d;
    end
  end

  assign push_o  = in_acc_i & ev_push;
  assign event_o = ev;

  // end of track always leaves running status cleared and a fresh delta
  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && event_o.kind == EV_END |=> rs_q == '0 && phase_q == PH_DELTA
                                         && delta_q == '0)
    else $error("end of track did not reset parser state");

endmodule

### sv/mtep_queue.sv
// ----------------------------------------------------------------------------
// mtep_queue: event queue
// Small FIFO of decoded events between the parser and the output stage.
// ----------------------------------------------------------------------------
module mtep_queue
  import mtep_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t push_data_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   head_valid_o,
  output event_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  event_t          mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("queue count beyond depth");

  a_push_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("event pushed into full queue");

endmodule

### sv/mtep_back.sv
// ----------------------------------------------------------------------------
// mtep_back: output stage
// Takes events from the queue, updates the channel mask and holds the result
// item until the consumer takes it.
// ----------------------------------------------------------------------------
module mtep_back
  import mtep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  event_t             head_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [1:0]         event_kind_o,
  output logic [3:0]         channel_o,
  output logic [7:0]         note_o,
  output logic [DeltaW-1:0]  delta_ticks_o,
  output logic [15:0]        channels_used_o
);

  logic          out_valid_q;
  event_t        out_q;
  logic [15:0]   mask_q, mask_d;
  logic [15:0]   used_q;
  logic          is_note;

  assign pop_o   = head_valid_i & (~out_valid_q | ~stall_i);
  assign is_note = (head_i.kind == EV_NOTE_OFF) || (head_i.kind == EV_NOTE_ON);

  always_comb begin
    mask_d = mask_q;
    if (is_note) begin
      mask_d = mask_q | (16'd1 << head_i.chan);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mask_q      <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        mask_q      <= mask_d;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q  <= head_i;
      used_q <= mask_d;
    end
  end

  assign valid_o         = out_valid_q;
  assign event_kind_o    = out_q.kind;
  assign channel_o       = out_q.chan;
  assign note_o          = out_q.note;
  assign delta_ticks_o   = out_q.delta;
  assign channels_used_o = used_q;

  // channel mask only ever gains bits
  a_mask_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (mask_q & $past(mask_q)) == $past(mask_q))
    else $error("channel mask lost a bit");

endmodule

### sv/midi_track_event_parser.sv
// Path: a byte that completes an event pushes it into the queue as the byte is
//   accepted; the item then passes to the output register, which drives valid_o.
// Throughput: one byte per cycle, bounded by the 2-entry event queue and the
//   output register; stall_o rises only while the queue is full.
// Reset: asynchronous, active low; parser waits for a delta time, running
//   status and channel mask are cleared, queue and output are emptied.
// ----------------------------------------------------------------------------
// midi_track_event_parser: MIDI track chunk event parser
// Byte parser front end, event queue and output stage with channel mask.
// ----------------------------------------------------------------------------
module midi_track_event_parser
  import mtep_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         stall_o,
  input  logic [7:0]   data_byte_i,
  output logic         valid_o,
  input  logic         stall_i,
  output logic [1:0]   event_kind_o,
  output logic [3:0]   channel_o,
  output logic [7:0]   note_o,
  output logic [27:0]  delta_ticks_o,
  output logic [15:0]  channels_used_o
);

  logic   in_acc;
  logic   push, full, pop, head_valid;
  event_t push_ev, head_ev;

  assign stall_o = full;
  assign in_acc  = valid_i & ~full;

  mtep_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .event_o     (push_ev)
  );

  mtep_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_ev),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_ev)
  );

  mtep_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head_ev),
    .pop_o           (pop),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .event_kind_o    (event_kind_o),
    .channel_o       (channel_o),
    .note_o          (note_o),
    .delta_ticks_o   (delta_ticks_o),
    .channels_used_o (channels_used_o)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for midi_track_event_parser
// Streams directed and random track bytes through the parser under random
// sender gaps and receiver stalls, predicts every note, end-of-track and
// error event, and compares each accepted event field by field.
// ----------------------------------------------------------------------------
import mtep_pkg::*;

typedef struct packed {
  event_kind_e        kind;
  logic [3:0]         chan;
  logic [7:0]         note;
  logic [DeltaW-1:0]  delta;
  logic [15:0]        used;
} track_event_t;

typedef struct {
  phase_e             phase;
  logic [7:0]         run_status;
  logic [DeltaW-1:0]  delta;
  logic [DeltaW-1:0]  skip_len;
  logic [7:0]         data1;
  logic               eot_pending;
  logic [15:0]        chan_mask;
} parser_state_t;

class track_scoreboard;
  parser_state_t state;
  track_event_t  expected_q[$];
  int unsigned   mismatches;

  function new();
    state = idle_state();
    mismatches = 0;
  endfunction

  static function parser_state_t idle_state();
    parser_state_t s;
    s.phase = PH_DELTA;
    s.run_status = '0;
    s.delta = '0;
    s.skip_len = '0;
    s.data1 = '0;
    s.eot_pending = 1'b0;
    s.chan_mask = '0;
    return s;
  endfunction

  static function track_event_t make_event(parser_state_t s, event_kind_e k,
                                           logic [3:0] ch, logic [7:0] nt);
    track_event_t ev;
    ev.kind = k;
    ev.chan = ch;
    ev.note = nt;
    ev.delta = s.delta;
    ev.used = s.chan_mask;
    return ev;
  endfunction

  // first data byte of a channel message, dispatched on running status
  static function bit take_data1(inout parser_state_t s, input logic [7:0] b,
                                 output track_event_t ev);
    s.data1 = b;
    ev = make_event(s, EV_ERROR, '0, b);
    case (s.run_status[7:4])
      CMD_NOTE_OFF, CMD_NOTE_ON: s.phase = PH_DATA2;
      CMD_POLY_AT, CMD_CTRL, CMD_BEND: s.phase = PH_SKIP2;
      CMD_PROG, CMD_PRESS: begin
        s.phase = PH_DELTA;
        s.delta = '0;
      end
      default: begin
        s.run_status = '0;
        s.phase = PH_DELTA;
        s.delta = '0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  static function bit end_skip(inout parser_state_t s, output track_event_t ev);
    bit got;
    got = s.eot_pending;
    ev = make_event(s, EV_END, '0, '0);
    if (got) s.run_status = '0;
    s.eot_pending = 1'b0;
    s.phase = PH_DELTA;
    s.delta = '0;
    return got;
  endfunction

  static function bit parse_byte(inout parser_state_t s, input logic [7:0] b,
                                 output track_event_t ev);
    bit got;
    logic [3:0] ch;
    got = 1'b0;
    ev = '0;
    case (s.phase)
      PH_HEAD: begin
        if (b == ST_SYSEX || b == ST_ESCAPE) begin
          s.run_status = '0;
          s.eot_pending = 1'b0;
          s.skip_len = '0;
          s.phase = PH_LEN;
        end else if (b >= ST_META_LO) begin
          s.eot_pending = (b == ST_META);
          s.phase = PH_META_TYPE;
        end else if (b[7]) begin
          s.run_status = b;
          s.phase = PH_DATA1;
        end else begin
          got = take_data1(s, b, ev);
        end
      end
      PH_DATA1: got = take_data1(s, b, ev);
      PH_DATA2: begin
        ch = s.run_status[3:0];
        s.chan_mask[ch] = 1'b1;
        ev = make_event(s, (s.run_status[7:4] == CMD_NOTE_ON && b != 8'h00) ?
                        EV_NOTE_ON : EV_NOTE_OFF, ch, s.data1);
        got = 1'b1;
        s.phase = PH_DELTA;
        s.delta = '0;
      end
      PH_SKIP2: begin
        s.phase = PH_DELTA;
        s.delta = '0;
      end
      PH_META_TYPE: begin
        if (b != META_EOT) s.eot_pending = 1'b0;
        s.skip_len = '0;
        s.phase = PH_LEN;
      end
      PH_LEN: begin
        s.skip_len = {s.skip_len[DeltaW-8:0], b[6:0]};
        if (!b[7]) begin
          if (s.skip_len == '0) got = end_skip(s, ev);
          else s.phase = PH_BODY;
        end
      end
      PH_BODY: begin
        s.skip_len = s.skip_len - DeltaW'(1);
        if (s.skip_len == '0) got = end_skip(s, ev);
      end
      default: begin
        s.delta = {s.delta[DeltaW-8:0], b[6:0]};
        s.phase = b[7] ? PH_DELTA : PH_HEAD;
      end
    endcase
    return got;
  endfunction

  function void note_byte(logic [7:0] b);
    track_event_t ev;
    if (parse_byte(state, b, ev)) expected_q.push_back(ev);
  endfunction

  function void check_event(track_event_t seen);
    track_event_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected event: event_kind %0d note %0d", seen.kind, seen.note);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (seen.kind !== want.kind) begin
      $error("event_kind: expected %0d, got %0d", want.kind, seen.kind);
      mismatches++;
    end
    if (seen.chan !== want.chan) begin
      $error("channel: expected %0d, got %0d", want.chan, seen.chan);
      mismatches++;
    end
    if (seen.note !== want.note) begin
      $error("note: expected %0d, got %0d", want.note, seen.note);
      mismatches++;
    end
    if (seen.delta !== want.delta) begin
      $error("delta_ticks: expected %0d, got %0d", want.delta, seen.delta);
      mismatches++;
    end
    if (seen.used !== want.used) begin
      $error("channels_used: expected %h, got %h", want.used, seen.used);
      mismatches++;
    end
  endfunction
endclass

module tb;
  localparam int StreamLen = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte = '0;
  logic               ev_valid;
  logic               ev_stall = 1'b0;
  logic [1:0]         ev_kind;
  logic [3:0]         ev_chan;
  logic [7:0]         ev_note;
  logic [DeltaW-1:0]  ev_delta;
  logic [15:0]        ev_used;

  track_scoreboard    board = new();
  logic [7:0]         stream_q[$];
  parser_state_t      gen_state;

  midi_track_event_parser i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .valid_i         (in_valid),
    .stall_o         (in_stall),
    .data_byte_i     (in_byte),
    .valid_o         (ev_valid),
    .stall_i         (ev_stall),
    .event_kind_o    (ev_kind),
    .channel_o       (ev_chan),
    .note_o          (ev_note),
    .delta_ticks_o   (ev_delta),
    .channels_used_o (ev_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- stream generation ----

  function automatic logic [7:0] rand_data();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
  endfunction

  function automatic void put_delta(ref logic [7:0] c[$]);
    int n;
    case ($urandom_range(0, 9))
      0:       n = $urandom_range(4, 5);
      1, 2:    n = $urandom_range(2, 3);
      default: n = 1;
    endcase
    for (int i = 1; i < n; i++) c.push_back(8'h80 | 8'($urandom_range(0, 127)));
    c.push_back(8'($urandom_range(0, 127)));
  endfunction

  // length and body of a sysex or meta event; sometimes a padded length
  function automatic void put_body(ref logic [7:0] c[$]);
    int len = $urandom_range(0, 6);
    if ($urandom_range(0, 4) == 0) c.push_back(8'h80);
    c.push_back(8'(len));
    repeat (len) c.push_back(8'($urandom));
  endfunction

  function automatic void make_candidate(ref logic [7:0] c[$]);
    int pick = $urandom_range(0, 99);
    logic [3:0] cmd;
    c.delete();
    if (pick >= 93) begin
      repeat ($urandom_range(1, 3)) c.push_back(8'($urandom));
      return;
    end
    put_delta(c);
    if (pick < 40) begin
      // omitted status byte means running status
      if ($urandom_range(0, 9) >= 3)
        c.push_back({$urandom_range(0, 1) ? CMD_NOTE_ON : CMD_NOTE_OFF, 4'($urandom)});
      c.push_back(rand_data());
      c.push_back(($urandom_range(0, 4) == 0) ? 8'h00 : rand_data());
    end else if (pick < 55) begin
      case ($urandom_range(0, 4))
        0:       cmd = CMD_POLY_AT;
        1:       cmd = CMD_CTRL;
        2:       cmd = CMD_BEND;
        3:       cmd = CMD_PROG;
        default: cmd = CMD_PRESS;
      endcase
      c.push_back({cmd, 4'($urandom)});
      c.push_back(rand_data());
      if (cmd != CMD_PROG && cmd != CMD_PRESS) c.push_back(rand_data());
    end else if (pick < 65) begin
      c.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_ESCAPE);
      put_body(c);
    end else if (pick < 77) begin
      c.push_back(($urandom_range(0, 4) == 0) ?
                  8'($urandom_range(ST_META_LO, ST_META)) : ST_META);
      c.push_back(($urandom_range(0, 2) == 0) ? META_EOT : 8'($urandom));
      put_body(c);
    end else if (pick < 85) begin
      if ($urandom_range(0, 1)) c.push_back(8'(ST_SYSEX + $urandom_range(1, 6)));
      c.push_back(rand_data());
    end else begin
      // channel event cut short
      c.push_back({4'($urandom_range(CMD_NOTE_OFF, CMD_BEND)), 4'($urandom)});
      if ($urandom_range(0, 1)) c.push_back(rand_data());
    end
  endfunction

  // keeps a stray length byte from swallowing the rest of the stream
  function automatic bit short_skip(parser_state_t s);
    return !(s.phase == PH_LEN || (s.phase == PH_BODY && s.skip_len > 40));
  endfunction

  function automatic void commit_byte(logic [7:0] b);
    track_event_t ev;
    stream_q.push_back(b);
    void'(board.parse_byte(gen_state, b, ev));
  endfunction

  function automatic void build_stream();
    logic [7:0] opening[$];
    logic [7:0] cand[$];
    parser_state_t trial;
    track_event_t ev;
    int tries;
    gen_state = board.idle_state();
    opening = '{
      8'h00, 8'h05,                                  // data byte, no status yet
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,             // delta wraps to 28 bits
      {CMD_NOTE_ON, 4'h0}, 8'h00, 8'h7F,
      8'h00, 8'h3C, 8'h00,                           // running status, velocity 0
      8'h81, 8'h00, {CMD_NOTE_OFF, 4'hF}, 8'h7F, 8'h40,
      8'h00, ST_SYSEX, 8'h00,                        // empty sysex
      8'h00, 8'(ST_SYSEX + 8'h01), 8'h22,            // undefined system status
      8'h00, ST_META, META_EOT, 8'h00
    };
    foreach (opening[i]) commit_byte(opening[i]);
    while (stream_q.size() < StreamLen) begin
      tries = 0;
      do begin
        make_candidate(cand);
        trial = gen_state;
        foreach (cand[i]) void'(board.parse_byte(trial, cand[i], ev));
        tries++;
      end while (!short_skip(trial) && tries < 8);
      if (short_skip(trial)) begin
        foreach (cand[i]) commit_byte(cand[i]);
      end else begin
        while (gen_state.phase != PH_DELTA) commit_byte(8'h00);
      end
    end
  endfunction

  // ---- monitors ----

  always @(posedge clk) begin
    if (rst_n && ev_valid && !ev_stall)
      board.check_event(track_event_t'({ev_kind, ev_chan, ev_note, ev_delta, ev_used}));
    if (rst_n && in_valid && !in_stall) board.note_byte(in_byte);
  end

  // receiver stall pattern: free, light, heavy and periodic stretches
  initial begin : ev_stall_gen
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(5, 80);
      end
      left--;
      case (mode)
        0:       ev_stall <= 1'b0;
        1:       ev_stall <= ($urandom_range(0, 3) == 0);
        2:       ev_stall <= ($urandom_range(0, 3) != 0);
        default: ev_stall <= ((left % 6) < 3);
      endcase
    end
  end

  initial begin : stimulus
    int burst;
    int gap;
    int pause_at;
    build_stream();
    pause_at = stream_q.size() / 2;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    burst = 0;
    foreach (stream_q[i]) begin
      if (i == pause_at) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (board.expected_q.size() != 0);
      end
      if (burst == 0) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      in_byte <= stream_q[i];
      do @(posedge clk); while (in_stall);
      burst--;
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_q.size() != 0);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
